// ----- sv/ydvr_pkg.sv -----
// shared constants, types and arctangent table for the yaw delta vector rotator
package ydvr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NCELL = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  localparam int IW = 16;
  localparam int OW = 17;
  localparam int XW = 33;
  localparam int ZW = 32;
  localparam int SW = 5;

  localparam logic [IW-1:0]        ANGLE_TURN = 16'd46080;
  localparam logic signed [XW-1:0] GAIN_Q30   = 33'sd652032874;
  localparam logic signed [ZW-1:0] Z_HALF     = 32'sd536870912;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    quad_t                quad;
    logic signed [IW-1:0] fwd;
    logic signed [IW-1:0] side;
  } cord_t;

  // atan(2^-i) in phase units, 2^32 per turn
  function automatic logic [ZW-1:0] atan_phase(input logic [SW-1:0] idx);
    logic [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/ydvr_phase.sv -----
// yaw difference reduction, phase conversion and quadrant split pipeline
module ydvr_phase (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic signed [ydvr_pkg::IW-1:0] old_yaw,
  input  logic signed [ydvr_pkg::IW-1:0] new_yaw,
  input  logic signed [ydvr_pkg::IW-1:0] forward_in,
  input  logic signed [ydvr_pkg::IW-1:0] side_in,
  output logic                           down_valid,
  input  logic                           down_ready,
  output ydvr_pkg::cord_t                down_data
);

  localparam logic signed [17:0] TURN_W  = 18'sd46080;
  localparam logic signed [17:0] TURN2_W = 18'sd92160;
  localparam logic signed [17:0] ZERO_W  = 18'sd0;
  localparam logic [31:0]        RECIP45 = 32'd93207;
  localparam logic [15:0]        DIV45   = 16'd45;
  localparam logic [21:0]        FRAC45  = 22'd93206;
  localparam logic [10:0]        REM45   = 11'd34;
  localparam logic [10:0]        RND45   = 11'd22;
  localparam logic [21:0]        RECIP45_S = 22'd1457;
  localparam logic [31:0]        QROUND  = 32'd536870912;

  // stage 1: angle difference reduced to one turn
  logic signed [16:0] diff;
  logic signed [17:0] diff_w;
  logic signed [17:0] d_wide;
  logic               s1_valid_r;
  logic               s1_ready;
  logic [15:0]        s1_d_r;
  logic signed [15:0] s1_f_r;
  logic signed [15:0] s1_s_r;

  // stage 2: quotient by 45
  logic [31:0]        prod_a;
  logic               s2_valid_r;
  logic               s2_ready;
  logic [15:0]        s2_d_r;
  logic [9:0]         s2_a_r;
  logic signed [15:0] s2_f_r;
  logic signed [15:0] s2_s_r;

  // stage 3: remainder
  logic [15:0]        a45;
  logic [15:0]        b_full;
  logic               s3_valid_r;
  logic               s3_ready;
  logic [9:0]         s3_a_r;
  logic [5:0]         s3_b_r;
  logic signed [15:0] s3_f_r;
  logic signed [15:0] s3_s_r;

  // stage 4: phase word
  logic [10:0]        num;
  logic [21:0]        c_prod;
  logic [21:0]        bt;
  logic [21:0]        t;
  logic               s4_valid_r;
  logic               s4_ready;
  logic [31:0]        s4_phase_r;
  logic signed [15:0] s4_f_r;
  logic signed [15:0] s4_s_r;

  // stage 5: quadrant and residual
  logic [31:0]        qsum;
  ydvr_pkg::cord_t    s5_nxt;
  logic               s5_valid_r;
  logic               s5_ready;
  ydvr_pkg::cord_t    s5_data_r;

  assign s1_ready = !s1_valid_r || s2_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign s4_ready = !s4_valid_r || s5_ready;
  assign s5_ready = !s5_valid_r || down_ready;
  assign up_ready = s1_ready;

  always_comb begin
    diff   = {new_yaw[15], new_yaw} - {old_yaw[15], old_yaw};
    diff_w = {diff[16], diff};
    if (diff_w >= TURN_W) begin
      d_wide = diff_w - TURN_W;
    end else if (diff_w >= ZERO_W) begin
      d_wide = diff_w;
    end else if (diff_w >= -TURN_W) begin
      d_wide = diff_w + TURN_W;
    end else begin
      d_wide = diff_w + TURN2_W;
    end
  end

  assign prod_a = 32'(s1_d_r) * RECIP45;
  assign a45    = 16'(s2_a_r) * DIV45;
  assign b_full = s2_d_r - a45;
  assign num    = 11'(s3_b_r) * REM45 + RND45;
  assign c_prod = 22'(num) * RECIP45_S;
  assign bt     = 22'(s3_b_r) * FRAC45;
  assign t      = bt + 22'(c_prod[21:16]);
  assign qsum   = s4_phase_r + QROUND;

  always_comb begin
    s5_nxt      = '0;
    s5_nxt.x    = ydvr_pkg::GAIN_Q30;
    s5_nxt.y    = '0;
    s5_nxt.z    = $signed({2'b00, qsum[29:0]}) - ydvr_pkg::Z_HALF;
    s5_nxt.quad = ydvr_pkg::quad_t'(qsum[31:30]);
    s5_nxt.fwd  = s4_f_r;
    s5_nxt.side = s4_s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= up_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
      if (s4_ready) s4_valid_r <= s3_valid_r;
      if (s5_ready) s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_d_r <= d_wide[15:0];
      s1_f_r <= forward_in;
      s1_s_r <= side_in;
    end
    if (s2_ready) begin
      s2_d_r <= s1_d_r;
      s2_a_r <= prod_a[31:22];
      s2_f_r <= s1_f_r;
      s2_s_r <= s1_s_r;
    end
    if (s3_ready) begin
      s3_a_r <= s2_a_r;
      s3_b_r <= b_full[5:0];
      s3_f_r <= s2_f_r;
      s3_s_r <= s2_s_r;
    end
    if (s4_ready) begin
      s4_phase_r <= {s3_a_r, t};
      s4_f_r     <= s3_f_r;
      s4_s_r     <= s3_s_r;
    end
    if (s5_ready) begin
      s5_data_r <= s5_nxt;
    end
  end

  assign down_valid = s5_valid_r;
  assign down_data  = s5_data_r;

`ifndef NO_ASSERTIONS
  a_angle_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_d_r < ydvr_pkg::ANGLE_TURN))
    else $error("reduced angle outside one turn");
  a_rem_below_45: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (s3_b_r <= 6'd44))
    else $error("remainder by 45 out of range");
  a_residual_range: assert property (@(posedge clk) disable iff (!rst_n)
    s5_valid_r |-> ($signed(s5_data_r.z) >= -ydvr_pkg::Z_HALF &&
                    $signed(s5_data_r.z) < ydvr_pkg::Z_HALF))
    else $error("residual angle beyond 45 degrees");
`endif

endmodule

// ----- sv/ydvr_cell.sv -----
// one rotation-mode cordic micro-rotation cell with its pipeline register
module ydvr_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ydvr_pkg::SW-1:0]   shift,
  input  logic [ydvr_pkg::ZW-1:0]   atan,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  ydvr_pkg::cord_t           up_data,
  output logic                      down_valid,
  input  logic                      down_ready,
  output ydvr_pkg::cord_t           down_data
);

  logic signed [ydvr_pkg::XW-1:0] x_in;
  logic signed [ydvr_pkg::XW-1:0] y_in;
  logic signed [ydvr_pkg::ZW-1:0] z_in;
  logic signed [ydvr_pkg::ZW-1:0] atan_s;
  logic signed [ydvr_pkg::XW-1:0] dx;
  logic signed [ydvr_pkg::XW-1:0] dy;
  ydvr_pkg::cord_t                data_nxt;
  ydvr_pkg::cord_t                data_r;
  logic                           valid_r;

  assign x_in   = up_data.x;
  assign y_in   = up_data.y;
  assign z_in   = up_data.z;
  assign atan_s = $signed(atan);
  assign dx     = y_in >>> shift;
  assign dy     = x_in >>> shift;

  always_comb begin
    data_nxt = up_data;
    if (!z_in[ydvr_pkg::ZW-1]) begin
      data_nxt.x = x_in - dx;
      data_nxt.y = y_in + dy;
      data_nxt.z = z_in - atan_s;
    end else begin
      data_nxt.x = x_in + dx;
      data_nxt.y = y_in - dy;
      data_nxt.z = z_in + atan_s;
    end
  end

  assign up_ready = !valid_r || down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign down_valid = valid_r;
  assign down_data  = data_r;

endmodule

// ----- sv/ydvr_mix.sv -----
// quadrant fold, vector multiply and rounding to the output register
module ydvr_mix (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  ydvr_pkg::cord_t                up_data,
  output logic                           down_valid,
  input  logic                           down_ready,
  output logic signed [ydvr_pkg::OW-1:0] forward_out,
  output logic signed [ydvr_pkg::OW-1:0] side_out
);

  localparam int PW = ydvr_pkg::XW + ydvr_pkg::IW;
  localparam int AW = PW + 1;
  localparam logic signed [AW-1:0] RND = AW'(64'sd536870912);
  localparam logic signed [19:0]   OUT_HI = 20'sd65535;
  localparam logic signed [19:0]   OUT_LO = -20'sd65536;

  function automatic logic signed [ydvr_pkg::OW-1:0] sat_out(input logic signed [19:0] v);
    logic signed [ydvr_pkg::OW-1:0] r;
    if (v > OUT_HI) begin
      r = 17'sd65535;
    end else if (v < OUT_LO) begin
      r = -17'sd65536;
    end else begin
      r = v[ydvr_pkg::OW-1:0];
    end
    return r;
  endfunction

  logic signed [ydvr_pkg::XW-1:0] x_in;
  logic signed [ydvr_pkg::XW-1:0] y_in;
  logic signed [ydvr_pkg::XW-1:0] c_nxt;
  logic signed [ydvr_pkg::XW-1:0] sn_nxt;

  logic                           q_valid_r;
  logic                           q_ready;
  logic signed [ydvr_pkg::XW-1:0] q_c_r;
  logic signed [ydvr_pkg::XW-1:0] q_sn_r;
  logic signed [ydvr_pkg::IW-1:0] q_f_r;
  logic signed [ydvr_pkg::IW-1:0] q_s_r;

  logic                           m_valid_r;
  logic                           m_ready;
  logic signed [PW-1:0]           m_cf_r;
  logic signed [PW-1:0]           m_ss_r;
  logic signed [PW-1:0]           m_sf_r;
  logic signed [PW-1:0]           m_cs_r;

  logic signed [AW-1:0]           fwd_acc;
  logic signed [AW-1:0]           side_acc;
  logic signed [19:0]             fwd_rnd;
  logic signed [19:0]             side_rnd;
  logic                           o_valid_r;
  logic                           o_ready;
  logic                           o_load;
  logic signed [ydvr_pkg::OW-1:0] o_fwd_r;
  logic signed [ydvr_pkg::OW-1:0] o_side_r;

  assign x_in = up_data.x;
  assign y_in = up_data.y;

  always_comb begin
    case (up_data.quad)
      ydvr_pkg::QUAD_0: begin
        c_nxt  = x_in;
        sn_nxt = y_in;
      end
      ydvr_pkg::QUAD_90: begin
        c_nxt  = -y_in;
        sn_nxt = x_in;
      end
      ydvr_pkg::QUAD_180: begin
        c_nxt  = -x_in;
        sn_nxt = -y_in;
      end
      default: begin
        c_nxt  = y_in;
        sn_nxt = -x_in;
      end
    endcase
  end

  assign o_ready  = !o_valid_r || down_ready;
  assign m_ready  = !m_valid_r || o_ready;
  assign q_ready  = !q_valid_r || m_ready;
  assign up_ready = q_ready;
  assign o_load   = o_ready && m_valid_r;

  // sums of products, rounded half up at 2^-30
  always_comb begin
    fwd_acc  = AW'(m_cf_r) - AW'(m_ss_r) + RND;
    side_acc = AW'(m_sf_r) + AW'(m_cs_r) + RND;
    fwd_rnd  = fwd_acc[AW-1:30];
    side_rnd = side_acc[AW-1:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (q_ready) q_valid_r <= up_valid;
      if (m_ready) m_valid_r <= q_valid_r;
      if (o_ready) o_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready) begin
      q_c_r  <= c_nxt;
      q_sn_r <= sn_nxt;
      q_f_r  <= up_data.fwd;
      q_s_r  <= up_data.side;
    end
    if (m_ready) begin
      m_cf_r <= PW'(q_c_r) * PW'(q_f_r);
      m_ss_r <= PW'(q_sn_r) * PW'(q_s_r);
      m_sf_r <= PW'(q_sn_r) * PW'(q_f_r);
      m_cs_r <= PW'(q_c_r) * PW'(q_s_r);
    end
    if (o_ready) begin
      o_fwd_r  <= sat_out(fwd_rnd);
      o_side_r <= sat_out(side_rnd);
    end
  end

  assign down_valid  = o_valid_r;
  assign forward_out = o_fwd_r;
  assign side_out    = o_side_r;

`ifndef NO_ASSERTIONS
  a_fwd_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    o_load |-> (fwd_rnd <= OUT_HI && fwd_rnd >= OUT_LO))
    else $error("forward result needs saturation");
  a_side_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    o_load |-> (side_rnd <= OUT_HI && side_rnd >= OUT_LO))
    else $error("side result needs saturation");
`endif

endmodule

// ----- sv/yaw_delta_vector_rotator.sv -----
// top level of the yaw delta vector rotator
// rotates a forward/side movement vector by the difference of two yaw angles.
// input channel in_*: one transaction carries old yaw, new yaw (1/128 degree)
// and the forward and side movement (1/64); any 16 bit pattern is legal.
// result channel out_*: one transaction per input with the rotated forward
// and side movement, 17 bit signed, in input order.
// path: from input acceptance to out_tvalid an item passes the angle to phase
// conversion stages, one register per cordic cell (NCELL cells, 16 by default)
// and the quadrant fold, multiply and round stages.
// throughput: one transaction per cycle while out_tready is high; each stage
// register takes new data whenever it is empty or its successor moves.
// when out_tready is low the result holds in the output register and the
// stages behind it keep filling their empty slots; in_tready drops only
// once every stage holds an item.
// reset (rst_n low, synchronous) empties the pipeline; no configuration.
module yaw_delta_vector_rotator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // old_yaw, new_yaw, forward_in, side_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // forward_out, side_out, zero fill
);

  localparam int N = ydvr_pkg::NCELL;

  ydvr_pkg::cord_t                chain_data  [N+1];
  logic                           chain_valid [N+1];
  logic                           chain_ready [N+1];
  logic signed [ydvr_pkg::OW-1:0] forward_out;
  logic signed [ydvr_pkg::OW-1:0] side_out;

  ydvr_phase u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .old_yaw    ($signed(in_tdata[15:0])),
    .new_yaw    ($signed(in_tdata[31:16])),
    .forward_in ($signed(in_tdata[47:32])),
    .side_in    ($signed(in_tdata[63:48])),
    .down_valid (chain_valid[0]),
    .down_ready (chain_ready[0]),
    .down_data  (chain_data[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    ydvr_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift      (ydvr_pkg::SW'(i)),
      .atan       (ydvr_pkg::atan_phase(ydvr_pkg::SW'(i))),
      .up_valid   (chain_valid[i]),
      .up_ready   (chain_ready[i]),
      .up_data    (chain_data[i]),
      .down_valid (chain_valid[i+1]),
      .down_ready (chain_ready[i+1]),
      .down_data  (chain_data[i+1])
    );
  end

  ydvr_mix u_mix (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (chain_valid[N]),
    .up_ready    (chain_ready[N]),
    .up_data     (chain_data[N]),
    .down_valid  (out_tvalid),
    .down_ready  (out_tready),
    .forward_out (forward_out),
    .side_out    (side_out)
  );

  assign out_tdata = {6'b000000, side_out, forward_out};

endmodule
